// File: rtl/rhht_pkg.sv
package rhht_pkg;

    // table geometry; the home slot keeps the low hash bits, so entries is a power of two
    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int KEY_BYTES     = 8;
    localparam int KEY_W         = 64;
    localparam int VAL_W         = 32;
    localparam int DIST_W        = 8;
    localparam int LIMIT_W       = 5;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd8;
    localparam logic [DIST_W-1:0]  SLOT_EMPTY  = 8'hFF;
    localparam logic [31:0]        HASH_START  = 32'd5381;
    localparam int                 HASH_SHIFT  = 5;

    typedef enum logic [2:0] {
        ACT_SET     = 3'd0,
        ACT_FIND    = 3'd1,
        ACT_REMOVE  = 3'd2,
        ACT_REM_VAL = 3'd3,
        ACT_CLEAR   = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_READ,
        ST_CHECK,
        ST_SHIFT_RD,
        ST_SHIFT_CHK,
        ST_CLEAR,
        ST_RESP
    } state_t;

    // probe distance of SLOT_EMPTY marks a free slot
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic [DIST_W-1:0] probe;
    } entry_t;

    // clear every byte from the first zero byte on
    function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] r;
        logic             live;
        r    = '0;
        live = 1'b1;
        for (int i = 0; i < KEY_BYTES; i++) begin
            if (k[KEY_W-1-8*i -: 8] == 8'd0) begin
                live = 1'b0;
            end
            if (live) begin
                r[KEY_W-1-8*i -: 8] = k[KEY_W-1-8*i -: 8];
            end
        end
        return r;
    endfunction

    // DJB2 over a normalized key; only the low index bits are kept
    function automatic logic [IDX_W-1:0] home_slot(input logic [KEY_W-1:0] k);
        logic [IDX_W-1:0] h;
        logic [7:0]       b;
        h = HASH_START[IDX_W-1:0];
        for (int i = 0; i < KEY_BYTES; i++) begin
            b = k[KEY_W-1-8*i -: 8];
            if (b != 8'd0) begin
                h = (h << HASH_SHIFT) + h + IDX_W'(b);
            end
        end
        return h;
    endfunction

endpackage

// File: rtl/robin_hood_hash_table_top.sv
// channel   direction  handshake              payload
// s_        in         s_tvalid / s_tready    tuser: action; tdata: key, value
// m_        out        m_tvalid / m_tready    tuser: status; tdata: found, value_out, evicted_key
// cfg_      in         cfg_valid / cfg_ready  cfg_data: probe_limit
// One item at a time; each probe, scan or shift step is an entry read, then a check and
// write back. Remove-by-value scans up to TABLE_ENTRIES steps plus the shift; clear marks
// every slot empty, unused actions respond without a table access. After reset (aresetn
// low, synchronous) a pass marks all slots empty with s_tready low; probe_limit resets to 8.
// A new item is taken while a result waits; a second result holds until m_tready frees it.
module robin_hood_hash_table_top
    import rhht_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [2:0]   s_tuser,    // action
    input  logic [95:0]  s_tdata,    // key[63:0], value[95:64]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [0:0]   m_tuser,    // status
    output logic [103:0] m_tdata,    // found[0], value_out[32:1], evicted_key[96:33], zero
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [4:0]   cfg_data    // probe_limit
);

    state_t              state_reg, state_next;
    action_t             act_reg, act_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [VAL_W-1:0]    val_reg, val_next;
    logic [DIST_W-1:0]   dist_reg, dist_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    prev_reg, prev_next;
    logic [LIMIT_W-1:0]  limit_reg;

    logic                res_found_reg, res_found_next;
    logic [VAL_W-1:0]    res_val_reg, res_val_next;
    logic                res_stat_reg, res_stat_next;
    logic [KEY_W-1:0]    res_key_reg, res_key_next;

    logic                m_valid_reg;
    logic                m_found_reg;
    logic [VAL_W-1:0]    m_val_reg;
    logic                m_stat_reg;
    logic [KEY_W-1:0]    m_key_reg;

    entry_t              mem [TABLE_ENTRIES];
    entry_t              rd_data_reg;
    logic [IDX_W-1:0]    rd_addr;
    logic                we;
    logic [IDX_W-1:0]    wa;
    entry_t              wd;

    logic                s_acc;
    logic [IDX_W-1:0]    idx_inc;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign idx_inc   = idx_reg + 1'b1;
    assign rd_addr   = idx_reg;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_stat_reg;
    assign m_tdata  = {7'd0, m_key_reg, m_val_reg, m_found_reg};

    // entry memory, one read and one write port, registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            limit_reg <= cfg_data;
        end
    end

    // control and working registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
        act_reg       <= act_next;
        key_reg       <= key_next;
        val_reg       <= val_next;
        dist_reg      <= dist_next;
        prev_reg      <= prev_next;
        res_found_reg <= res_found_next;
        res_val_reg   <= res_val_next;
        res_stat_reg  <= res_stat_next;
        res_key_reg   <= res_key_next;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_RESP && (!m_valid_reg || m_tready)) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (state_reg == ST_RESP && (!m_valid_reg || m_tready)) begin
            m_found_reg <= res_found_reg;
            m_val_reg   <= res_val_reg;
            m_stat_reg  <= res_stat_reg;
            m_key_reg   <= res_key_reg;
        end
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        act_next       = act_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        dist_next      = dist_reg;
        idx_next       = idx_reg;
        prev_next      = prev_reg;
        res_found_next = res_found_reg;
        res_val_next   = res_val_reg;
        res_stat_next  = res_stat_reg;
        res_key_next   = res_key_reg;
        we      = 1'b0;
        wa      = idx_reg;
        wd      = '{key: key_reg, value: val_reg, probe: dist_reg};

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    act_next       = action_t'(s_tuser);
                    key_next       = norm_key(s_tdata[63:0]);
                    val_next       = s_tdata[95:64];
                    dist_next      = '0;
                    res_found_next = 1'b0;
                    res_val_next   = '0;
                    res_stat_next  = 1'b0;
                    res_key_next   = '0;
                    case (action_t'(s_tuser))
                        ACT_SET, ACT_FIND, ACT_REMOVE: begin
                            idx_next   = home_slot(norm_key(s_tdata[63:0]));
                            state_next = ST_READ;
                        end
                        ACT_REM_VAL: begin
                            idx_next   = '0;
                            state_next = ST_READ;
                        end
                        ACT_CLEAR: begin
                            idx_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        default: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            // mark every slot empty, one per cycle
            ST_INIT, ST_CLEAR: begin
                we       = 1'b1;
                wd       = '{key: '0, value: '0, probe: SLOT_EMPTY};
                idx_next = idx_inc;
                if (idx_reg == IDX_W'(TABLE_ENTRIES - 1)) begin
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_RESP;
                end
            end

            ST_READ: begin
                state_next = ST_CHECK;
            end

            ST_CHECK: begin
                state_next = ST_READ;
                idx_next   = idx_inc;
                case (act_reg)
                    ACT_SET: begin
                        if (rd_data_reg.probe == SLOT_EMPTY ||
                            (rd_data_reg.probe == dist_reg && rd_data_reg.key == key_reg)) begin
                            we         = 1'b1;
                            idx_next   = idx_reg;
                            state_next = ST_RESP;
                        end else if (dist_reg > DIST_W'(limit_reg)) begin
                            res_val_next  = val_reg;
                            res_stat_next = 1'b1;
                            res_key_next  = key_reg;
                            idx_next      = idx_reg;
                            state_next    = ST_RESP;
                        end else if (dist_reg > rd_data_reg.probe) begin
                            // richer slot: trade places and carry its entry on
                            we        = 1'b1;
                            key_next  = rd_data_reg.key;
                            val_next  = rd_data_reg.value;
                            dist_next = rd_data_reg.probe + 1'b1;
                        end else begin
                            dist_next = dist_reg + 1'b1;
                        end
                    end
                    ACT_FIND, ACT_REMOVE: begin
                        if (rd_data_reg.probe == SLOT_EMPTY || dist_reg > rd_data_reg.probe) begin
                            idx_next   = idx_reg;
                            state_next = ST_RESP;
                        end else if (rd_data_reg.probe == dist_reg &&
                                     rd_data_reg.key == key_reg) begin
                            if (act_reg == ACT_FIND) begin
                                res_found_next = 1'b1;
                                res_val_next   = rd_data_reg.value;
                                idx_next       = idx_reg;
                                state_next     = ST_RESP;
                            end else begin
                                prev_next  = idx_reg;
                                state_next = ST_SHIFT_RD;
                            end
                        end else begin
                            dist_next = dist_reg + 1'b1;
                        end
                    end
                    ACT_REM_VAL: begin
                        // linear scan in index order
                        if (rd_data_reg.probe != SLOT_EMPTY && rd_data_reg.value == val_reg) begin
                            prev_next  = idx_reg;
                            state_next = ST_SHIFT_RD;
                        end else if (idx_reg == IDX_W'(TABLE_ENTRIES - 1)) begin
                            idx_next   = idx_reg;
                            state_next = ST_RESP;
                        end
                    end
                    default: begin
                        state_next = ST_RESP;
                    end
                endcase
            end

            ST_SHIFT_RD: begin
                state_next = ST_SHIFT_CHK;
            end

            // backward shift: pull displaced followers one slot back; the hole
            // at prev is filled by the follower or finally marked empty
            ST_SHIFT_CHK: begin
                we = 1'b1;
                wa = prev_reg;
                if (rd_data_reg.probe != SLOT_EMPTY && rd_data_reg.probe != '0) begin
                    wd         = '{key: rd_data_reg.key, value: rd_data_reg.value,
                                   probe: rd_data_reg.probe - 1'b1};
                    prev_next  = idx_reg;
                    idx_next   = idx_inc;
                    state_next = ST_SHIFT_RD;
                end else begin
                    wd             = '{key: '0, value: '0, probe: SLOT_EMPTY};
                    res_found_next = 1'b1;
                    state_next     = ST_RESP;
                end
            end

            ST_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
